>>> hdl/pvrb_pkg.sv
package pvrb_pkg;

	// Angle arithmetic in 1/128 degree; the register holds 17 bits, reduction runs on 18.
	localparam int ANGLE_W = 17;
	localparam int AW      = 18;
	localparam logic signed [AW-1:0] ANG_FULL    = 18'sd46080;
	localparam logic signed [AW-1:0] ANG_HALF    = 18'sd23040;
	localparam logic signed [AW-1:0] ANG_QUARTER = 18'sd11520;

	// Residual angle of the rotation chain in 2^-16 degree.
	localparam int ZW        = 25;
	localparam int ZSHIFT    = 9;
	localparam int ATAN_LEN  = 24;

	localparam logic signed [ZW-1:0] ATAN_DEG16 [ATAN_LEN] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
		25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
		25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
		25'sd917,     25'sd458,     25'sd229,    25'sd115,
		25'sd57,      25'sd29,      25'sd14,     25'sd7,
		25'sd4,       25'sd2,       25'sd1,      25'sd0
	};

	// Inverse chain gain as a Q30 fraction.
	localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
	localparam int                 GUARD_BITS = 8;
	localparam int                 GAIN_SHIFT = 30 - GUARD_BITS;

	localparam int CFG_IW = 3;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ANGLE     = 3'd0,
		CFG_ORIGIN_X  = 3'd1,
		CFG_ORIGIN_Y  = 3'd2,
		CFG_MOVE_X    = 3'd3,
		CFG_MOVE_Y    = 3'd4,
		CFG_LEFT_SIDE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic vld;
		logic last;
	} pipe_ctl_t;

endpackage

>>> hdl/pvrb_cordic_cell.sv
module pvrb_cordic_cell #(
	parameter int W     = 35,
	parameter int STAGE = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvrb_pkg::pipe_ctl_t           in_ctl,
	input  logic signed [W-1:0]           in_x,
	input  logic signed [W-1:0]           in_y,
	input  logic signed [pvrb_pkg::ZW-1:0] in_z,
	output logic                          in_rdy,
	output pvrb_pkg::pipe_ctl_t           out_ctl,
	output logic signed [W-1:0]           out_x,
	output logic signed [W-1:0]           out_y,
	output logic signed [pvrb_pkg::ZW-1:0] out_z,
	input  logic                          out_rdy
);

	pvrb_pkg::pipe_ctl_t            ctl_q;
	logic signed [W-1:0]            x_q;
	logic signed [W-1:0]            y_q;
	logic signed [pvrb_pkg::ZW-1:0] z_q;
	logic signed [W-1:0]            xs;
	logic signed [W-1:0]            ys;

	// Arithmetic shift of a signed value is a floor shift.
	assign xs     = in_x >>> STAGE;
	assign ys     = in_y >>> STAGE;
	assign in_rdy = !ctl_q.vld || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (in_rdy) begin
			ctl_q <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_ctl.vld) begin
			if (!in_z[pvrb_pkg::ZW-1]) begin
				x_q <= in_x - ys;
				y_q <= in_y + xs;
				z_q <= in_z - pvrb_pkg::ATAN_DEG16[STAGE];
			end else begin
				x_q <= in_x + ys;
				y_q <= in_y - xs;
				z_q <= in_z + pvrb_pkg::ATAN_DEG16[STAGE];
			end
		end
	end

	assign out_ctl = ctl_q;
	assign out_x   = x_q;
	assign out_y   = y_q;
	assign out_z   = z_q;

endmodule

>>> hdl/pvrb_bbox.sv
module pvrb_bbox #(
	parameter int C = 24,
	parameter int W = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pvrb_pkg::pipe_ctl_t  in_ctl,
	input  logic signed [W-1:0]  in_x,
	input  logic signed [W-1:0]  in_y,
	input  logic signed [C-1:0]  origin_x,
	input  logic signed [C-1:0]  origin_y,
	output logic                 in_rdy,
	output logic                 out_vld,
	output logic [C-1:0]         rot_x,
	output logic [C-1:0]         rot_y,
	output logic                 box_valid,
	output logic [C-1:0]         box_min_x,
	output logic [C-1:0]         box_min_y,
	output logic [C-1:0]         box_width,
	output logic [C-1:0]         box_height,
	input  logic                 out_rdy
);

	localparam int RW = W - pvrb_pkg::GUARD_BITS;
	localparam int VW = RW + 1;

	logic signed [W-1:0]  xh;
	logic signed [W-1:0]  yh;
	logic signed [VW-1:0] vx;
	logic signed [VW-1:0] vy;
	logic signed [C-1:0]  sx;
	logic signed [C-1:0]  sy;

	pvrb_pkg::pipe_ctl_t  ctl_s1;
	logic signed [C-1:0]  rx_s1;
	logic signed [C-1:0]  ry_s1;
	logic                 rdy_s1;
	logic                 load_out;

	logic                 out_vld_q;
	logic [C-1:0]         rot_x_q;
	logic [C-1:0]         rot_y_q;
	logic                 box_valid_q;
	logic [C-1:0]         box_min_x_q;
	logic [C-1:0]         box_min_y_q;
	logic [C-1:0]         box_width_q;
	logic [C-1:0]         box_height_q;

	logic                 started_q;
	logic signed [C-1:0]  run_min_x_q;
	logic signed [C-1:0]  run_max_x_q;
	logic signed [C-1:0]  run_min_y_q;
	logic signed [C-1:0]  run_max_y_q;
	logic signed [C-1:0]  nmin_x;
	logic signed [C-1:0]  nmax_x;
	logic signed [C-1:0]  nmin_y;
	logic signed [C-1:0]  nmax_y;

	// Round half up to the coordinate grid, then put the origin back.
	assign xh = in_x + W'(1 << (pvrb_pkg::GUARD_BITS - 1));
	assign yh = in_y + W'(1 << (pvrb_pkg::GUARD_BITS - 1));
	assign vx = VW'($signed(xh[W-1:pvrb_pkg::GUARD_BITS])) + VW'(origin_x);
	assign vy = VW'($signed(yh[W-1:pvrb_pkg::GUARD_BITS])) + VW'(origin_y);

	always_comb begin
		if (vx[VW-1:C-1] == {(VW-C+1){vx[VW-1]}}) begin
			sx = vx[C-1:0];
		end else begin
			sx = {vx[VW-1], {(C-1){~vx[VW-1]}}};
		end
		if (vy[VW-1:C-1] == {(VW-C+1){vy[VW-1]}}) begin
			sy = vy[C-1:0];
		end else begin
			sy = {vy[VW-1], {(C-1){~vy[VW-1]}}};
		end
	end

	assign load_out = !out_vld_q || out_rdy;
	assign rdy_s1   = !ctl_s1.vld || load_out;
	assign in_rdy   = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rdy_s1) begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ctl.vld) begin
			rx_s1 <= sx;
			ry_s1 <= sy;
		end
	end

	// The first vertex of a run seeds all four extremes.
	always_comb begin
		nmin_x = (!started_q || rx_s1 < run_min_x_q) ? rx_s1 : run_min_x_q;
		nmax_x = (!started_q || rx_s1 > run_max_x_q) ? rx_s1 : run_max_x_q;
		nmin_y = (!started_q || ry_s1 < run_min_y_q) ? ry_s1 : run_min_y_q;
		nmax_y = (!started_q || ry_s1 > run_max_y_q) ? ry_s1 : run_max_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			started_q   <= 1'b0;
			run_min_x_q <= '0;
			run_max_x_q <= '0;
			run_min_y_q <= '0;
			run_max_y_q <= '0;
		end else if (load_out) begin
			out_vld_q <= ctl_s1.vld;
			if (ctl_s1.vld) begin
				started_q   <= !ctl_s1.last;
				run_min_x_q <= nmin_x;
				run_max_x_q <= nmax_x;
				run_min_y_q <= nmin_y;
				run_max_y_q <= nmax_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && ctl_s1.vld) begin
			rot_x_q     <= rx_s1;
			rot_y_q     <= ry_s1;
			box_valid_q <= ctl_s1.last;
			if (ctl_s1.last) begin
				box_min_x_q  <= nmin_x;
				box_min_y_q  <= nmin_y;
				box_width_q  <= nmax_x - nmin_x;
				box_height_q <= nmax_y - nmin_y;
			end else begin
				box_min_x_q  <= '0;
				box_min_y_q  <= '0;
				box_width_q  <= '0;
				box_height_q <= '0;
			end
		end
	end

	assign out_vld    = out_vld_q;
	assign rot_x      = rot_x_q;
	assign rot_y      = rot_y_q;
	assign box_valid  = box_valid_q;
	assign box_min_x  = box_min_x_q;
	assign box_min_y  = box_min_y_q;
	assign box_width  = box_width_q;
	assign box_height = box_height_q;

endmodule

>>> hdl/polygon_vertex_rotate_bbox_top.sv
// Channel  Direction  Handshake                Content
// s_       in         s_tvalid / s_tready      vertex in s_tdata, end of polygon in s_tlast
// m_       out        m_tvalid / m_tready      rotated vertex and box in m_tdata, box flag in m_tuser
// cfg_     in         cfg_valid / cfg_ready    register index and write data
//
// One item per cycle sustained while m_tready stays high; registered steps in order: offset,
// origin difference, gain multiply, one cell per CORDIC stage, rounding, output register.
// Reset loads the register defaults, clears the running box and empties every stage.
// Each stage holds its item only while the next one is full and stalled, so back pressure on
// m_ passes combinationally upstream through full stages and empty stages keep filling.
// cfg_ready is always high.
module polygon_vertex_rotate_bbox_top #(
	parameter int COORD_WIDTH   = 24,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// start_x, start_y, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// rot_x, rot_y, box_min_x, box_min_y, box_width, box_height, zero fill
	output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// box_valid
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pvrb_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [((COORD_WIDTH > 17) ? COORD_WIDTH : 17)-1:0] cfg_data
);

	localparam int C   = COORD_WIDTH;
	localparam int N   = CORDIC_STAGES;
	localparam int W   = C + 11;
	localparam int DW  = C + 2;
	localparam int PW  = C + 33;
	localparam int OTW = ((6*COORD_WIDTH+7)/8)*8;

	// Configuration registers.
	logic signed [pvrb_pkg::ANGLE_W-1:0] angle_q;
	logic signed [C-1:0]                 origin_x_q;
	logic signed [C-1:0]                 origin_y_q;
	logic signed [C-1:0]                 move_x_q;
	logic signed [C-1:0]                 move_y_q;
	logic                                left_side_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q     <= '0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			move_x_q    <= '0;
			move_y_q    <= '0;
			left_side_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pvrb_pkg::CFG_ANGLE:     angle_q     <= cfg_data[pvrb_pkg::ANGLE_W-1:0];
				pvrb_pkg::CFG_ORIGIN_X:  origin_x_q  <= cfg_data[C-1:0];
				pvrb_pkg::CFG_ORIGIN_Y:  origin_y_q  <= cfg_data[C-1:0];
				pvrb_pkg::CFG_MOVE_X:    move_x_q    <= cfg_data[C-1:0];
				pvrb_pkg::CFG_MOVE_Y:    move_y_q    <= cfg_data[C-1:0];
				pvrb_pkg::CFG_LEFT_SIDE: left_side_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Angle reduction: remainder of a full turn, wrap into a half turn either side, then fold
	// anything past a quarter turn by a half turn with both coordinates negated.
	logic signed [pvrb_pkg::AW-1:0] a0;
	logic signed [pvrb_pkg::AW-1:0] a1;
	logic signed [pvrb_pkg::AW-1:0] a2;
	logic signed [pvrb_pkg::AW-1:0] a3;
	logic                           flip;
	logic signed [pvrb_pkg::ZW-1:0] z_init;

	always_comb begin
		a0 = pvrb_pkg::AW'(angle_q);
		if (a0 >= pvrb_pkg::ANG_FULL) begin
			a1 = a0 - pvrb_pkg::ANG_FULL;
		end else if (a0 <= -pvrb_pkg::ANG_FULL) begin
			a1 = a0 + pvrb_pkg::ANG_FULL;
		end else begin
			a1 = a0;
		end
		if (a1 >= pvrb_pkg::ANG_HALF) begin
			a2 = a1 - pvrb_pkg::ANG_FULL;
		end else if (a1 < -pvrb_pkg::ANG_HALF) begin
			a2 = a1 + pvrb_pkg::ANG_FULL;
		end else begin
			a2 = a1;
		end
		if (a2 > pvrb_pkg::ANG_QUARTER) begin
			a3   = a2 - pvrb_pkg::ANG_HALF;
			flip = 1'b1;
		end else if (a2 < -pvrb_pkg::ANG_QUARTER) begin
			a3   = a2 + pvrb_pkg::ANG_HALF;
			flip = 1'b1;
		end else begin
			a3   = a2;
			flip = 1'b0;
		end
		z_init = pvrb_pkg::ZW'(a3) <<< pvrb_pkg::ZSHIFT;
	end

	// Stage 1: offset add with saturation; start_x is subtracted instead when left_side is clear.
	logic signed [C-1:0] start_x;
	logic signed [C-1:0] start_y;
	logic signed [C:0]   sum_x;
	logic signed [C:0]   sum_y;
	logic signed [C-1:0] sat_x;
	logic signed [C-1:0] sat_y;

	assign start_x = s_tdata[C-1:0];
	assign start_y = s_tdata[2*C-1:C];
	assign sum_x   = left_side_q ? ((C+1)'(move_x_q) + (C+1)'(start_x))
	                             : ((C+1)'(move_x_q) - (C+1)'(start_x));
	assign sum_y   = (C+1)'(move_y_q) + (C+1)'(start_y);
	assign sat_x   = (sum_x[C] != sum_x[C-1]) ? {sum_x[C], {(C-1){~sum_x[C]}}} : sum_x[C-1:0];
	assign sat_y   = (sum_y[C] != sum_y[C-1]) ? {sum_y[C], {(C-1){~sum_y[C]}}} : sum_y[C-1:0];

	pvrb_pkg::pipe_ctl_t ctl_s1;
	pvrb_pkg::pipe_ctl_t ctl_s2;
	pvrb_pkg::pipe_ctl_t ctl_s3;
	pvrb_pkg::pipe_ctl_t in_ctl;
	logic signed [C-1:0]  px_s1;
	logic signed [C-1:0]  py_s1;
	logic signed [DW-1:0] dx_s2;
	logic signed [DW-1:0] dy_s2;
	logic signed [W-1:0]  x0_s3;
	logic signed [W-1:0]  y0_s3;
	logic signed [pvrb_pkg::ZW-1:0] z0_s3;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;

	// Stage 2: exact difference to the origin, negated for a folded angle.
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;

	assign dx = flip ? (DW'(origin_x_q) - DW'(px_s1)) : (DW'(px_s1) - DW'(origin_x_q));
	assign dy = flip ? (DW'(origin_y_q) - DW'(py_s1)) : (DW'(py_s1) - DW'(origin_y_q));

	// Stage 3: gain compensation, keeping GUARD_BITS extra fraction bits.
	logic signed [PW-1:0] prod_x;
	logic signed [PW-1:0] prod_y;

	assign prod_x = PW'(dx_s2) * PW'(pvrb_pkg::GAIN_Q30);
	assign prod_y = PW'(dy_s2) * PW'(pvrb_pkg::GAIN_Q30);

	pvrb_pkg::pipe_ctl_t            cctl [N+1];
	logic signed [W-1:0]            cx   [N+1];
	logic signed [W-1:0]            cy   [N+1];
	logic signed [pvrb_pkg::ZW-1:0] cz   [N+1];
	logic                           crdy [N+1];

	assign in_ctl.vld  = s_tvalid;
	assign in_ctl.last = s_tlast;
	assign rdy_s3      = !ctl_s3.vld || crdy[0];
	assign rdy_s2      = !ctl_s2.vld || rdy_s3;
	assign rdy_s1      = !ctl_s1.vld || rdy_s2;
	assign s_tready    = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (rdy_s1) begin
				ctl_s1 <= in_ctl;
			end
			if (rdy_s2) begin
				ctl_s2 <= ctl_s1;
			end
			if (rdy_s3) begin
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ctl.vld) begin
			px_s1 <= sat_x;
			py_s1 <= sat_y;
		end
		if (rdy_s2 && ctl_s1.vld) begin
			dx_s2 <= dx;
			dy_s2 <= dy;
		end
		if (rdy_s3 && ctl_s2.vld) begin
			x0_s3 <= prod_x[pvrb_pkg::GAIN_SHIFT +: W];
			y0_s3 <= prod_y[pvrb_pkg::GAIN_SHIFT +: W];
			z0_s3 <= z_init;
		end
	end

	assign cctl[0] = ctl_s3;
	assign cx[0]   = x0_s3;
	assign cy[0]   = y0_s3;
	assign cz[0]   = z0_s3;

	for (genvar i = 0; i < N; i++) begin : g_cell
		pvrb_cordic_cell #(
			.W     (W),
			.STAGE (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_ctl  (cctl[i]),
			.in_x    (cx[i]),
			.in_y    (cy[i]),
			.in_z    (cz[i]),
			.in_rdy  (crdy[i]),
			.out_ctl (cctl[i+1]),
			.out_x   (cx[i+1]),
			.out_y   (cy[i+1]),
			.out_z   (cz[i+1]),
			.out_rdy (crdy[i+1])
		);
	end

	logic [C-1:0] rot_x;
	logic [C-1:0] rot_y;
	logic         box_valid;
	logic [C-1:0] box_min_x;
	logic [C-1:0] box_min_y;
	logic [C-1:0] box_width;
	logic [C-1:0] box_height;

	pvrb_bbox #(
		.C (C),
		.W (W)
	) u_bbox (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ctl     (cctl[N]),
		.in_x       (cx[N]),
		.in_y       (cy[N]),
		.origin_x   (origin_x_q),
		.origin_y   (origin_y_q),
		.in_rdy     (crdy[N]),
		.out_vld    (m_tvalid),
		.rot_x      (rot_x),
		.rot_y      (rot_y),
		.box_valid  (box_valid),
		.box_min_x  (box_min_x),
		.box_min_y  (box_min_y),
		.box_width  (box_width),
		.box_height (box_height),
		.out_rdy    (m_tready)
	);

	assign m_tdata = OTW'({box_height, box_width, box_min_y, box_min_x, rot_y, rot_x});
	assign m_tuser = box_valid;

`ifndef SYNTHESIS
	// With the output register empty, every stage upstream can take an item.
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

	// Items that close no run carry an all-zero box.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !box_valid) |->
			(box_min_x == '0 && box_min_y == '0 && box_width == '0 && box_height == '0))
		else $error("box fields set on an item that closes no run");

	// The closing vertex of a run lies inside the box it reports.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && box_valid) |->
			((C'(rot_x - box_min_x) <= box_width) && (C'(rot_y - box_min_y) <= box_height)))
		else $error("closing vertex outside its own bounding box");
`endif

endmodule

>>> verif/tb_polygon_vertex_rotate_bbox_top.sv
module tb_polygon_vertex_rotate_bbox_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW             = 24;
	localparam int CFG_W          = (CW > pvrb_pkg::ANGLE_W) ? CW : pvrb_pkg::ANGLE_W;
	localparam int STAGES         = 16;
	localparam int LATENCY        = STAGES + 5;
	localparam int IDLE_PCT       = 13;
	localparam int CALM_FROM      = 600;
	localparam int CALM_TO        = 850;
	localparam int STALL_AT       = 300;
	localparam int STALL_LEN      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;
	localparam longint C_MAX      = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint C_MIN      = -C_MAX - 1;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [pvrb_pkg::CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [pvrb_pkg::CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CW-1:0] start_x;
		logic [CW-1:0] start_y;
		logic          last;
	} vertex_item_t;

	typedef struct packed {
		logic [CW-1:0] rot_x;
		logic [CW-1:0] rot_y;
		logic          box_valid;
		logic [CW-1:0] box_min_x;
		logic [CW-1:0] box_min_y;
		logic [CW-1:0] box_width;
		logic [CW-1:0] box_height;
	} vertex_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [((2*CW+7)/8)*8-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [((6*CW+7)/8)*8-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pvrb_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	polygon_vertex_rotate_bbox_top #(
		.COORD_WIDTH(CW),
		.CORDIC_STAGES(STAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block's registers and running box.
	longint mdl_angle = 0;
	longint mdl_origin_x = 0;
	longint mdl_origin_y = 0;
	longint mdl_move_x = 0;
	longint mdl_move_y = 0;
	logic   mdl_left_side = 1'b1;
	longint run_min_x = 0;
	longint run_max_x = 0;
	longint run_min_y = 0;
	longint run_max_y = 0;
	logic   run_open = 1'b0;

	vertex_item_t   pending_vertices[$];
	vertex_result_t expected_vertices[$];
	int queued_cnt = 0;
	int sent_cnt = 0;
	int recv_cnt = 0;
	int mismatch_cnt = 0;

	function automatic longint sat_coord(longint v);
		if (v > C_MAX)
			return C_MAX;
		if (v < C_MIN)
			return C_MIN;
		return v;
	endfunction

	task automatic rotate_about_origin(input longint px, input longint py,
			output longint rx, output longint ry);
		longint dx, dy, a, x, y, z, xs, ys;
		dx = px - mdl_origin_x;
		dy = py - mdl_origin_y;
		a = mdl_angle % longint'(pvrb_pkg::ANG_FULL);
		if (a >= longint'(pvrb_pkg::ANG_HALF))
			a -= longint'(pvrb_pkg::ANG_FULL);
		if (a < -longint'(pvrb_pkg::ANG_HALF))
			a += longint'(pvrb_pkg::ANG_FULL);
		// Past a quarter turn the chain would not converge, so turn by half first.
		if (a > longint'(pvrb_pkg::ANG_QUARTER)) begin
			a -= longint'(pvrb_pkg::ANG_HALF);
			dx = -dx;
			dy = -dy;
		end else if (a < -longint'(pvrb_pkg::ANG_QUARTER)) begin
			a += longint'(pvrb_pkg::ANG_HALF);
			dx = -dx;
			dy = -dy;
		end
		x = (dx * longint'(pvrb_pkg::GAIN_Q30)) >>> pvrb_pkg::GAIN_SHIFT;
		y = (dy * longint'(pvrb_pkg::GAIN_Q30)) >>> pvrb_pkg::GAIN_SHIFT;
		z = a <<< pvrb_pkg::ZSHIFT;
		for (int i = 0; i < STAGES && i < pvrb_pkg::ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z -= longint'(pvrb_pkg::ATAN_DEG16[i]);
			end else begin
				x = x + ys;
				y = y - xs;
				z += longint'(pvrb_pkg::ATAN_DEG16[i]);
			end
		end
		x = (x + (longint'(1) <<< (pvrb_pkg::GUARD_BITS - 1))) >>> pvrb_pkg::GUARD_BITS;
		y = (y + (longint'(1) <<< (pvrb_pkg::GUARD_BITS - 1))) >>> pvrb_pkg::GUARD_BITS;
		rx = sat_coord(x + mdl_origin_x);
		ry = sat_coord(y + mdl_origin_y);
	endtask

	task automatic transform_vertex(input vertex_item_t it, output vertex_result_t r);
		longint sx, sy, px, py, rx, ry, span_x, span_y;
		sx = longint'($signed(it.start_x));
		sy = longint'($signed(it.start_y));
		px = sat_coord(mdl_left_side ? mdl_move_x + sx : mdl_move_x - sx);
		py = sat_coord(mdl_move_y + sy);
		rotate_about_origin(px, py, rx, ry);
		if (!run_open) begin
			run_min_x = rx;
			run_max_x = rx;
			run_min_y = ry;
			run_max_y = ry;
			run_open = 1'b1;
		end else begin
			if (rx < run_min_x) run_min_x = rx;
			if (rx > run_max_x) run_max_x = rx;
			if (ry < run_min_y) run_min_y = ry;
			if (ry > run_max_y) run_max_y = ry;
		end
		r = '0;
		r.rot_x = rx[CW-1:0];
		r.rot_y = ry[CW-1:0];
		if (it.last) begin
			span_x = run_max_x - run_min_x;
			span_y = run_max_y - run_min_y;
			r.box_valid = 1'b1;
			r.box_min_x = run_min_x[CW-1:0];
			r.box_min_y = run_min_y[CW-1:0];
			r.box_width = span_x[CW-1:0];
			r.box_height = span_y[CW-1:0];
			run_open = 1'b0;
		end
	endtask

	task automatic apply_reg(logic [pvrb_pkg::CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			pvrb_pkg::CFG_ANGLE:
				mdl_angle = longint'($signed(data[pvrb_pkg::ANGLE_W-1:0]));
			pvrb_pkg::CFG_ORIGIN_X:  mdl_origin_x = longint'($signed(data[CW-1:0]));
			pvrb_pkg::CFG_ORIGIN_Y:  mdl_origin_y = longint'($signed(data[CW-1:0]));
			pvrb_pkg::CFG_MOVE_X:    mdl_move_x = longint'($signed(data[CW-1:0]));
			pvrb_pkg::CFG_MOVE_Y:    mdl_move_y = longint'($signed(data[CW-1:0]));
			pvrb_pkg::CFG_LEFT_SIDE: mdl_left_side = data[0];
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(string what, logic [CW-1:0] want, logic [CW-1:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t: result %0d %s expected %h got %h", $realtime, recv_cnt, what,
				want, got);
	endtask

	task automatic check_vertex_result();
		vertex_result_t got, want;
		got.rot_x = m_tdata[0*CW +: CW];
		got.rot_y = m_tdata[1*CW +: CW];
		got.box_min_x = m_tdata[2*CW +: CW];
		got.box_min_y = m_tdata[3*CW +: CW];
		got.box_width = m_tdata[4*CW +: CW];
		got.box_height = m_tdata[5*CW +: CW];
		got.box_valid = m_tuser;
		if (expected_vertices.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("%0t: result with nothing expected, rot_x %h rot_y %h", $realtime,
					got.rot_x, got.rot_y);
		end else begin
			want = expected_vertices.pop_front();
			if (got.rot_x !== want.rot_x) flag_mismatch("rot_x", want.rot_x, got.rot_x);
			if (got.rot_y !== want.rot_y) flag_mismatch("rot_y", want.rot_y, got.rot_y);
			if (got.box_valid !== want.box_valid)
				flag_mismatch("box_valid", CW'(want.box_valid), CW'(got.box_valid));
			if (got.box_min_x !== want.box_min_x)
				flag_mismatch("box_min_x", want.box_min_x, got.box_min_x);
			if (got.box_min_y !== want.box_min_y)
				flag_mismatch("box_min_y", want.box_min_y, got.box_min_y);
			if (got.box_width !== want.box_width)
				flag_mismatch("box_width", want.box_width, got.box_width);
			if (got.box_height !== want.box_height)
				flag_mismatch("box_height", want.box_height, got.box_height);
		end
	endtask

	// Vertex driver: predicts each accepted item and offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		vertex_item_t it;
		vertex_result_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				it.start_x = s_tdata[0 +: CW];
				it.start_y = s_tdata[CW +: CW];
				it.last = s_tlast;
				transform_vertex(it, r);
				expected_vertices.push_back(r);
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_vertices.size() > 0 &&
						((sent_cnt >= CALM_FROM && sent_cnt < CALM_TO) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					it = pending_vertices.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {it.start_y, it.start_x};
					s_tlast <= it.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with its own random back pressure and one long hold-off.
	int stall_left = 0;
	logic stall_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_vertex_result();
				recv_cnt++;
			end
			if (!stall_done && recv_cnt == STALL_AT) begin
				stall_done = 1'b1;
				stall_left = STALL_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (recv_cnt >= CALM_FROM && recv_cnt < CALM_TO) ||
					$urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [pvrb_pkg::CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Bits above the angle width are filled at random; the block must drop them.
	function automatic logic [CFG_W-1:0] angle_word(int a);
		logic [CFG_W-1:0] w;
		w = CFG_W'($urandom);
		w[pvrb_pkg::ANGLE_W-1:0] = a[pvrb_pkg::ANGLE_W-1:0];
		return w;
	endfunction

	function automatic logic [CFG_W-1:0] side_word(logic side);
		logic [CFG_W-1:0] w;
		w = CFG_W'($urandom);
		w[0] = side;
		return w;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		longint v;
		case ($urandom_range(9))
			0: v = C_MIN;
			1: v = C_MAX;
			2, 3, 4, 5: v = longint'($urandom_range(8191)) - 4096;
			default: v = longint'($urandom);
		endcase
		return v[CW-1:0];
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(11))
			0: return 0;
			1: return int'(pvrb_pkg::ANG_FULL);
			2: return -int'(pvrb_pkg::ANG_FULL);
			3: return int'(pvrb_pkg::ANG_QUARTER);
			4: return -int'(pvrb_pkg::ANG_QUARTER);
			5: return int'(pvrb_pkg::ANG_HALF);
			6: return (1 << (pvrb_pkg::ANGLE_W - 1)) - 1;
			7: return -(1 << (pvrb_pkg::ANGLE_W - 1));
			default: return int'($urandom_range(2 * 46080)) - 46080;
		endcase
	endfunction

	task automatic queue_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
		vertex_item_t it;
		it.start_x = x;
		it.start_y = y;
		it.last = last;
		pending_vertices.push_back(it);
		queued_cnt++;
	endtask

	task automatic queue_polygon(int len);
		for (int i = 0; i < len; i++)
			queue_vertex(rand_coord(), rand_coord(), i == len - 1);
	endtask

	task automatic queue_polygons(int count);
		int len;
		while (count > 0) begin
			len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 10);
			if (len > count)
				len = count;
			queue_polygon(len);
			count -= len;
		end
	endtask

	// Waits until every queued vertex has been accepted and every result has come back.
	task automatic drain();
		while (sent_cnt != queued_cnt || expected_vertices.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_random_setting();
		write_reg(pvrb_pkg::CFG_ANGLE, angle_word(rand_angle()));
		write_reg(pvrb_pkg::CFG_ORIGIN_X, rand_coord());
		write_reg(pvrb_pkg::CFG_ORIGIN_Y, rand_coord());
		write_reg(pvrb_pkg::CFG_MOVE_X, rand_coord());
		write_reg(pvrb_pkg::CFG_MOVE_Y, rand_coord());
		write_reg(pvrb_pkg::CFG_LEFT_SIDE, side_word($urandom_range(1)));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: identity transform, single-vertex runs and a run over the coordinate extremes.
		queue_vertex('0, '0, 1'b1);
		queue_vertex(C_MAX[CW-1:0], C_MAX[CW-1:0], 1'b0);
		queue_vertex(C_MIN[CW-1:0], C_MIN[CW-1:0], 1'b0);
		queue_vertex(C_MAX[CW-1:0], C_MIN[CW-1:0], 1'b0);
		queue_vertex(C_MIN[CW-1:0], C_MAX[CW-1:0], 1'b1);
		queue_vertex(CW'(1), {CW{1'b1}}, 1'b1);
		drain();

		// Quarter turn with mirrored x and offsets that force saturation.
		write_reg(pvrb_pkg::CFG_ANGLE, angle_word(int'(pvrb_pkg::ANG_QUARTER)));
		write_reg(pvrb_pkg::CFG_ORIGIN_X, CW'(1000));
		write_reg(pvrb_pkg::CFG_ORIGIN_Y, CW'(-2000));
		write_reg(pvrb_pkg::CFG_MOVE_X, C_MAX[CW-1:0]);
		write_reg(pvrb_pkg::CFG_MOVE_Y, C_MIN[CW-1:0]);
		write_reg(pvrb_pkg::CFG_LEFT_SIDE, side_word(1'b0));
		queue_vertex(C_MIN[CW-1:0], C_MIN[CW-1:0], 1'b0);
		queue_vertex(C_MAX[CW-1:0], C_MAX[CW-1:0], 1'b1);
		queue_vertex(CW'(256), CW'(512), 1'b1);
		drain();

		// Angles past a full turn in both directions, and writes to unused indexes.
		write_reg(pvrb_pkg::CFG_ANGLE, angle_word((1 << (pvrb_pkg::ANGLE_W - 1)) - 1));
		write_reg(pvrb_pkg::CFG_ORIGIN_X, C_MIN[CW-1:0]);
		write_reg(pvrb_pkg::CFG_MOVE_X, '0);
		write_reg(pvrb_pkg::CFG_MOVE_Y, '0);
		write_reg(pvrb_pkg::CFG_LEFT_SIDE, side_word(1'b1));
		write_reg(CFG_SPARE_LO, {CFG_W{1'b1}});
		write_reg(CFG_SPARE_HI, CFG_W'($urandom));
		queue_vertex(CW'(-300), CW'(4000), 1'b0);
		queue_vertex(CW'(12345), CW'(-777), 1'b0);
		queue_vertex(C_MAX[CW-1:0], '0, 1'b1);
		drain();
		write_reg(pvrb_pkg::CFG_ANGLE, angle_word(-(1 << (pvrb_pkg::ANGLE_W - 1))));
		write_reg(pvrb_pkg::CFG_ORIGIN_Y, C_MAX[CW-1:0]);
		queue_vertex(CW'(5000), CW'(-5000), 1'b0);
		queue_vertex(C_MIN[CW-1:0], CW'(77), 1'b1);
		drain();

		// Exactly half a turn, and the negative quarter turn.
		write_reg(pvrb_pkg::CFG_ANGLE, angle_word(int'(pvrb_pkg::ANG_HALF)));
		queue_vertex(CW'(2560), CW'(-1280), 1'b0);
		queue_vertex(CW'(-9), CW'(33), 1'b1);
		drain();
		write_reg(pvrb_pkg::CFG_ANGLE, angle_word(-int'(pvrb_pkg::ANG_QUARTER)));
		write_reg(pvrb_pkg::CFG_ORIGIN_X, '0);
		write_reg(pvrb_pkg::CFG_ORIGIN_Y, '0);
		queue_vertex(CW'(1024), CW'(2048), 1'b0);
		queue_vertex(CW'(-4096), CW'(100), 1'b0);
		queue_vertex(CW'(3), CW'(-3), 1'b1);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			program_random_setting();
			queue_polygons(100);
			// In one phase the sender stops until the pipeline has emptied.
			if (phase == 3)
				drain();
			queue_polygons(100);
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (expected_vertices.size() != 0) begin
			mismatch_cnt++;
			$display("%0t: %0d results never arrived", $realtime, expected_vertices.size());
		end
		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/pvrb_pkg.sv
hdl/pvrb_cordic_cell.sv
hdl/pvrb_bbox.sv
hdl/polygon_vertex_rotate_bbox_top.sv
verif/tb_polygon_vertex_rotate_bbox_top.sv
